>>> hw/rtl/beep_pattern_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Beep pattern sequencer assertion macros
// Concurrent check helpers shared by the sequencer RTL. Defining ASSERT_OFF
// removes every check.
// ----------------------------------------------------------------------------
`ifndef BEEP_PATTERN_SEQUENCER_ASSERT_SVH
`define BEEP_PATTERN_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define BPS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BPS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/bps_pkg.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer package
// Shared types, constants and helper functions of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

  // Request queue depth and the widths that follow from it.
  localparam int QUEUE_DEPTH = 4;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int TP_W    = 16;
  localparam int CPM_W   = 20;
  localparam int CNT_W   = 16;
  localparam int MS_W    = 16;
  localparam int VOL_W   = 2;
  localparam int LEVEL_W = 3;

  // Configuration port.
  localparam int CFG_AW = 1;
  localparam int CFG_DW = 20;
  localparam logic [CFG_AW-1:0] CFG_TONE_PERIOD   = 1'd0;
  localparam logic [CFG_AW-1:0] CFG_CLOCKS_PER_MS = 1'd1;

  // Configuration reset values.
  localparam logic [TP_W-1:0]  TONE_PERIOD_RST   = 16'd8333;
  localparam logic [CPM_W-1:0] CLOCKS_PER_MS_RST = 20'd25000;

  // Volume codes.
  localparam logic [VOL_W-1:0] VOL_MUTE = 2'd0;
  localparam logic [VOL_W-1:0] VOL_LOW  = 2'd1;
  localparam logic [VOL_W-1:0] VOL_MED  = 2'd2;
  localparam logic [VOL_W-1:0] VOL_HIGH = 2'd3;

  // Number of queue entries popped in one step.
  localparam logic [1:0] POP_NONE = 2'd0;
  localparam logic [1:0] POP_ONE  = 2'd1;
  localparam logic [1:0] POP_TWO  = 2'd2;

  // Pattern phase.
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_ON   = 3'b010,
    PH_OFF  = 3'b100
  } phase_t;

  // One beep request as queued.
  typedef struct packed {
    logic [VOL_W-1:0] volume;
    logic [CNT_W-1:0] count;
    logic [MS_W-1:0]  on_ms;
    logic [MS_W-1:0]  off_ms;
  } bps_req_t;

  // Configuration with precomputed PWM match values.
  typedef struct packed {
    logic [TP_W-1:0]  tone_period;
    logic [TP_W-1:0]  match_low;
    logic [TP_W-1:0]  match_med;
    logic [CPM_W-1:0] clocks_per_ms;
  } cfg_t;

  // Queue contents seen by the engine after this step's push.
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    bps_req_t          head0;
    bps_req_t          head1;
  } queue_view_t;

  // Result fields produced by the engine.
  typedef struct packed {
    logic               tone_out;
    logic               busy_res;
    logic [LEVEL_W-1:0] queue_level;
  } res_t;

  // Unsigned 16-bit divide by five through a reciprocal multiply.
  function automatic logic [TP_W-1:0] div5_u16(input logic [TP_W-1:0] x);
    logic [31:0] prod;
    prod = 32'(x) * 32'd52429;
    return TP_W'(prod[31:18]);
  endfunction

  // Reset value of the match values, derived from the reset period.
  localparam logic [TP_W-1:0] MATCH_LOW_RST = 16'd416;
  localparam logic [TP_W-1:0] MATCH_MED_RST = 16'd1666;

endpackage

`default_nettype wire

>>> hw/rtl/beep_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer
// Buzzer pattern engine with a queued request FIFO and a built-in PWM tone.
// ----------------------------------------------------------------------------
// Each input beat is either one PWM clock tick (cmd 0) or a beep request
// (cmd 1), and each produces exactly one result beat carrying the tone pin
// level, the busy flag, the queue level and the drop flag. The block takes
// one beat per clock while the output is not stalled: a beat waits in the
// input register, the whole pattern step runs in the logic after it, and the
// result lands in the output register, which raises out_valid.
// The pattern state is updated once per beat, which is what sets the rate.
// No clearing pass follows reset; configuration writes act at once.
// ----------------------------------------------------------------------------
`default_nettype none
`include "beep_pattern_sequencer_assert.svh"

module beep_pattern_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Configuration write port.
  input  wire logic                         cfg_we,
  input  wire logic [bps_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [bps_pkg::CFG_DW-1:0]   cfg_wdata,
  // Input channel.
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_cmd,
  input  wire logic [bps_pkg::VOL_W-1:0]    in_volume,
  input  wire logic [bps_pkg::CNT_W-1:0]    in_repeat_count,
  input  wire logic [bps_pkg::MS_W-1:0]     in_on_ms,
  input  wire logic [bps_pkg::MS_W-1:0]     in_off_ms,
  // Result channel.
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_tone_out,
  output logic                              out_busy_res,
  output logic [bps_pkg::LEVEL_W-1:0]       out_queue_level,
  output logic                              out_request_dropped
);
  import bps_pkg::*;

  cfg_t        cfg;
  queue_view_t qview;
  res_t        eng_res;
  logic [1:0]  pop_cnt;
  logic        q_dropped;

  logic        hold_valid_r;
  logic        hold_cmd_r;
  bps_req_t    hold_req_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        out_dropped_r;
  logic        out_adv;
  logic        step;
  logic        in_acc;

  // Handshake: the result register frees up when empty or taken.
  assign out_adv  = !out_valid_r || !out_stall;
  assign step     = hold_valid_r && out_adv;
  assign in_stall = hold_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_acc) begin
      hold_valid_r <= 1'b1;
    end else if (step) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hold_cmd_r        <= in_cmd;
      hold_req_r.volume <= in_volume;
      hold_req_r.count  <= in_repeat_count;
      hold_req_r.on_ms  <= in_on_ms;
      hold_req_r.off_ms <= in_off_ms;
    end
  end

  bps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bps_req_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_req  (step && hold_cmd_r),
    .push_data (hold_req_r),
    .pop_cnt   (pop_cnt),
    .qview     (qview),
    .dropped   (q_dropped)
  );

  bps_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .cmd     (hold_cmd_r),
    .cfg     (cfg),
    .qview   (qview),
    .pop_cnt (pop_cnt),
    .res     (eng_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_adv) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r     <= eng_res;
      out_dropped_r <= q_dropped;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tone_out        = out_res_r.tone_out;
  assign out_busy_res        = out_res_r.busy_res;
  assign out_queue_level     = out_res_r.queue_level;
  assign out_request_dropped = out_dropped_r;

  // The tone pin is only driven while a pattern runs.
  `BPS_ASSERT_IMP(a_tone_needs_busy, clk, rst_n, out_valid_r && out_res_r.tone_out, out_res_r.busy_res)
  // Every processed beat leaves a result in the output register.
  `BPS_ASSERT_NXT(a_step_gives_result, clk, rst_n, step, out_valid_r)
  // A held beat that is not processed stays in the input register.
  `BPS_ASSERT_NXT(a_hold_kept, clk, rst_n, hold_valid_r && !step, hold_valid_r)

endmodule

`default_nettype wire

>>> hw/rtl/bps_cfg_regs.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer configuration registers
// Holds tone period and millisecond scale and derives the PWM match values
// for low and medium volume when the period is written.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_cfg_regs (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [bps_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [bps_pkg::CFG_DW-1:0] cfg_wdata,
  output bps_pkg::cfg_t                  cfg
);
  import bps_pkg::*;

  cfg_t            cfg_r;
  logic [TP_W-1:0] wr_period;

  assign wr_period = cfg_wdata[TP_W-1:0];

  // Register writes; period/20 is (period/4)/5.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tone_period   <= TONE_PERIOD_RST;
      cfg_r.match_low     <= MATCH_LOW_RST;
      cfg_r.match_med     <= MATCH_MED_RST;
      cfg_r.clocks_per_ms <= CLOCKS_PER_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TONE_PERIOD: begin
          cfg_r.tone_period <= wr_period;
          cfg_r.match_low   <= div5_u16(wr_period >> 2);
          cfg_r.match_med   <= div5_u16(wr_period);
        end
        CFG_CLOCKS_PER_MS: begin
          cfg_r.clocks_per_ms <= cfg_wdata[CPM_W-1:0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hw/rtl/bps_req_queue.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer request queue
// Shift-style request FIFO: entry 0 is the head. Checks and pushes new
// requests and removes up to two entries per step.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_req_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_req,
  input  wire bps_pkg::bps_req_t push_data,
  input  wire logic [1:0]        pop_cnt,
  output bps_pkg::queue_view_t   qview,
  output logic                   dropped
);
  import bps_pkg::*;

  bps_req_t          q_r     [QUEUE_DEPTH];
  bps_req_t          q_nxt   [QUEUE_DEPTH];
  bps_req_t          view_all[QUEUE_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_pushed;
  logic              invalid;
  logic              full;
  logic              do_push;

  // Request check: zero count, zero on time or a full queue drops it.
  assign invalid = (push_data.count == '0) || (push_data.on_ms == '0);
  assign full    = (fill_r == FILL_W'(QUEUE_DEPTH));
  assign dropped = push_req && (invalid || full);
  assign do_push = push_req && !dropped;

  assign fill_pushed = fill_r + FILL_W'(do_push);

  // Contents after the push: the new request lands at the fill position.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_view
    assign view_all[i] = (do_push && (fill_r == FILL_W'(i))) ? push_data : q_r[i];
  end

  // Shift down by the number of popped entries.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_shift
    if (i + 2 < QUEUE_DEPTH) begin : g_two
      assign q_nxt[i] = (pop_cnt == POP_TWO) ? view_all[i+2] :
                        (pop_cnt == POP_ONE) ? view_all[i+1] : view_all[i];
    end else if (i + 1 < QUEUE_DEPTH) begin : g_one
      assign q_nxt[i] = (pop_cnt == POP_ONE) ? view_all[i+1] : view_all[i];
    end else begin : g_last
      assign q_nxt[i] = view_all[i];
    end
  end

  // Entry storage needs no reset: only entries below the fill are read.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_pushed - FILL_W'(pop_cnt);
    end
  end

  assign qview.fill  = fill_pushed;
  assign qview.head0 = view_all[0];
  if (QUEUE_DEPTH > 1) begin : g_head1
    assign qview.head1 = view_all[1];
  end else begin : g_head1_none
    assign qview.head1 = view_all[0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/bps_engine.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer engine
// Pattern state, PWM counter and millisecond timing. Performs one step per
// processed item and computes the tone, busy and queue level results.
// ----------------------------------------------------------------------------
`default_nettype none

module bps_engine (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic                 cmd,
  input  wire bps_pkg::cfg_t        cfg,
  input  wire bps_pkg::queue_view_t qview,
  output logic [1:0]                pop_cnt,
  output bps_pkg::res_t             res
);
  import bps_pkg::*;

  typedef struct packed {
    phase_t             phase;
    logic [CNT_W-1:0]   cycles_left;
    logic [MS_W-1:0]    ms_left;
    logic [CPM_W-1:0]   ms_prescaler;
    bps_req_t           active;
  } eng_state_t;

  eng_state_t       st_r;
  eng_state_t       st_nxt;
  logic [TP_W-1:0]  pwm_r;
  logic [TP_W-1:0]  pwm_nxt;
  logic [MS_W-1:0]  ms_dec;
  logic             cyc_end;
  logic [TP_W-1:0]  match;

  // State after loading a request; mute leaves the engine idle.
  function automatic eng_state_t load_req(input bps_req_t r);
    eng_state_t s;
    s.active       = r;
    s.ms_prescaler = '0;
    if (r.volume == VOL_MUTE) begin
      s.phase       = PH_IDLE;
      s.cycles_left = '0;
      s.ms_left     = '0;
    end else begin
      s.phase       = PH_ON;
      s.cycles_left = r.count;
      s.ms_left     = r.on_ms;
    end
    return s;
  endfunction

  // One step: tick timing, cycle end, then the idle take.
  always_comb begin
    st_nxt  = st_r;
    pwm_nxt = pwm_r;
    pop_cnt = POP_NONE;
    ms_dec  = st_r.ms_left - MS_W'(st_r.ms_left != '0);
    cyc_end = 1'b0;

    if (step && !cmd) begin
      // Free-running PWM counter.
      if (({1'b0, pwm_r} + 17'd1) >= {1'b0, cfg.tone_period}) begin
        pwm_nxt = '0;
      end else begin
        pwm_nxt = pwm_r + TP_W'(1);
      end

      // Millisecond prescaler runs only while a pattern is active.
      if (st_r.phase != PH_IDLE) begin
        if (({1'b0, st_r.ms_prescaler} + 21'd1) >= {1'b0, cfg.clocks_per_ms}) begin
          st_nxt.ms_prescaler = '0;
          st_nxt.ms_left      = ms_dec;
          if (ms_dec == '0) begin
            if (st_r.phase == PH_ON) begin
              st_nxt.phase   = PH_OFF;
              st_nxt.ms_left = st_r.active.off_ms;
              cyc_end        = (st_r.active.off_ms == '0);
            end else begin
              cyc_end = 1'b1;
            end
          end
        end else begin
          st_nxt.ms_prescaler = st_r.ms_prescaler + CPM_W'(1);
        end
      end

      // End of one on/off cycle: a queued request replaces the pattern.
      if (cyc_end) begin
        st_nxt.cycles_left = st_r.cycles_left - CNT_W'(1);
        if (qview.fill != '0) begin
          st_nxt  = load_req(qview.head0);
          pop_cnt = POP_ONE;
        end else if (st_nxt.cycles_left == '0) begin
          st_nxt.phase        = PH_IDLE;
          st_nxt.ms_left      = '0;
          st_nxt.ms_prescaler = '0;
        end else begin
          st_nxt.phase   = PH_ON;
          st_nxt.ms_left = st_r.active.on_ms;
        end
      end
    end

    // An idle engine takes the next queued request.
    if (step && (st_nxt.phase == PH_IDLE) &&
        ((FILL_W+1)'(qview.fill) > (FILL_W+1)'(pop_cnt))) begin
      if (pop_cnt == POP_NONE) begin
        st_nxt  = load_req(qview.head0);
        pop_cnt = POP_ONE;
      end else begin
        st_nxt  = load_req(qview.head1);
        pop_cnt = POP_TWO;
      end
    end
  end

  // PWM match value for the active volume.
  always_comb begin
    unique case (st_nxt.active.volume)
      VOL_LOW:  match = cfg.match_low;
      VOL_MED:  match = cfg.match_med;
      VOL_HIGH: match = cfg.tone_period;
      default:  match = '0;
    endcase
  end

  assign res.tone_out    = (st_nxt.phase == PH_ON) && (pwm_nxt < match);
  assign res.busy_res    = (st_nxt.phase != PH_IDLE);
  assign res.queue_level = LEVEL_W'(qview.fill - FILL_W'(pop_cnt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase        <= PH_IDLE;
      st_r.cycles_left  <= '0;
      st_r.ms_left      <= '0;
      st_r.ms_prescaler <= '0;
      st_r.active       <= '0;
      pwm_r             <= '0;
    end else begin
      st_r  <= st_nxt;
      pwm_r <= pwm_nxt;
    end
  end

endmodule

`default_nettype wire

>>> tb/beep_result_checker.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer status checker
// Watches the request and status channels of the sequencer and keeps its
// own model of the request queue, the pattern engine and the PWM tone. Each
// accepted input beat yields one predicted status beat. Each status beat
// that leaves the block is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------

package bps_tb_pkg;

  // Input beat kinds.
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // One status beat as it leaves the sequencer.
  typedef struct packed {
    logic                        tone;
    logic                        busy;
    logic [bps_pkg::LEVEL_W-1:0] level;
    logic                        dropped;
  } beep_status_t;

endpackage

module beep_result_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bps_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [bps_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [bps_pkg::VOL_W-1:0]    in_volume,
  input  logic [bps_pkg::CNT_W-1:0]    in_repeat_count,
  input  logic [bps_pkg::MS_W-1:0]     in_on_ms,
  input  logic [bps_pkg::MS_W-1:0]     in_off_ms,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_tone_out,
  input  logic                         out_busy_res,
  input  logic [bps_pkg::LEVEL_W-1:0]  out_queue_level,
  input  logic                         out_request_dropped,
  output int                           fail_count,
  output int                           status_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;
  import bps_tb_pkg::*;

  // Model of the request queue.
  bps_req_t         req_ring [QUEUE_DEPTH];
  int               ring_head;
  int               ring_fill;

  // Model of the pattern engine and the tone generator.
  phase_t           eng_phase;
  bps_req_t         cur_req;
  logic [CNT_W-1:0] reps_left;
  logic [MS_W-1:0]  ms_count;
  logic [CPM_W-1:0] ms_divider;
  logic [TP_W-1:0]  pwm_count;

  // Register copies.
  logic [TP_W-1:0]  period_reg;
  logic [CPM_W-1:0] ms_clocks_reg;

  // Status beats predicted but not yet seen.
  beep_status_t     status_due [$];

  // Make a request the running pattern; a mute request leaves the engine idle.
  function automatic void load_req(input bps_req_t r);
    cur_req    = r;
    ms_divider = '0;
    if (r.volume == VOL_MUTE) begin
      eng_phase = PH_IDLE;
      reps_left = '0;
      ms_count  = '0;
    end else begin
      eng_phase = PH_ON;
      reps_left = r.count;
      ms_count  = r.on_ms;
    end
  endfunction

  function automatic void pop_req();
    bps_req_t r;
    if (ring_fill == 0) return;
    r         = req_ring[ring_head];
    ring_head = (ring_head + 1) % QUEUE_DEPTH;
    ring_fill--;
    load_req(r);
  endfunction

  // End of one on/off cycle: a queued request replaces the rest of the pattern.
  function automatic void end_cycle();
    reps_left = reps_left - 1'b1;
    if (ring_fill > 0) begin
      pop_req();
    end else if (reps_left == '0) begin
      eng_phase  = PH_IDLE;
      ms_count   = '0;
      ms_divider = '0;
    end else begin
      eng_phase = PH_ON;
      ms_count  = cur_req.on_ms;
    end
  endfunction

  // One millisecond has passed in the on or off phase.
  function automatic void ms_elapsed();
    if (ms_count != '0) ms_count--;
    if (ms_count != '0) return;
    if (eng_phase == PH_ON) begin
      eng_phase = PH_OFF;
      ms_count  = cur_req.off_ms;
      if (ms_count == '0) end_cycle();
    end else begin
      end_cycle();
    end
  endfunction

  // One PWM clock: the tone counter always runs, the ms divider only when busy.
  function automatic void pwm_tick();
    if (32'(pwm_count) + 1 >= 32'(period_reg)) pwm_count = '0;
    else pwm_count++;
    if (eng_phase != PH_IDLE) begin
      if (32'(ms_divider) + 1 >= 32'(ms_clocks_reg)) begin
        ms_divider = '0;
        ms_elapsed();
      end else begin
        ms_divider++;
      end
    end
  endfunction

  function automatic logic pwm_level();
    logic [TP_W-1:0] match_val;
    if (eng_phase != PH_ON) return 1'b0;
    case (cur_req.volume)
      VOL_LOW:  match_val = period_reg / 20;
      VOL_MED:  match_val = period_reg / 5;
      VOL_HIGH: match_val = period_reg;
      default:  match_val = '0;
    endcase
    return pwm_count < match_val;
  endfunction

  // Apply one input beat to the model and return the status it produces.
  function automatic beep_status_t step_engine(
    input logic             cmd,
    input logic [VOL_W-1:0] vol,
    input logic [CNT_W-1:0] reps,
    input logic [MS_W-1:0]  on_ms,
    input logic [MS_W-1:0]  off_ms
  );
    beep_status_t s;
    bps_req_t     r;
    logic         drop;
    drop = 1'b0;
    if (cmd == CMD_REQUEST) begin
      r.volume = vol;
      r.count  = reps;
      r.on_ms  = on_ms;
      r.off_ms = off_ms;
      if (reps == '0 || on_ms == '0 || ring_fill >= QUEUE_DEPTH) begin
        drop = 1'b1;
      end else begin
        req_ring[(ring_head + ring_fill) % QUEUE_DEPTH] = r;
        ring_fill++;
      end
    end else begin
      pwm_tick();
    end
    // An idle engine takes the next request at once.
    if (eng_phase == PH_IDLE && ring_fill > 0) pop_req();
    s.tone    = pwm_level();
    s.busy    = (eng_phase != PH_IDLE);
    s.level   = LEVEL_W'(ring_fill);
    s.dropped = drop;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Track configuration writes, predict accepted inputs, check accepted outputs.
  always @(posedge clk) begin
    beep_status_t want;
    if (!rst_n) begin
      ring_head     = 0;
      ring_fill     = 0;
      eng_phase     = PH_IDLE;
      cur_req       = '0;
      reps_left     = '0;
      ms_count      = '0;
      ms_divider    = '0;
      pwm_count     = '0;
      period_reg    = TONE_PERIOD_RST;
      ms_clocks_reg = CLOCKS_PER_MS_RST;
      fail_count    = 0;
      status_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_TONE_PERIOD:   period_reg    = cfg_wdata[TP_W-1:0];
          CFG_CLOCKS_PER_MS: ms_clocks_reg = cfg_wdata[CPM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        status_due.push_back(step_engine(in_cmd, in_volume, in_repeat_count,
                                         in_on_ms, in_off_ms));
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          $display("%0t: status beat with none expected, tone %0b busy %0b level %0d drop %0b",
                   $time, out_tone_out, out_busy_res, out_queue_level,
                   out_request_dropped);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          check_field("tone_out", 8'(want.tone), 8'(out_tone_out));
          check_field("busy_res", 8'(want.busy), 8'(out_busy_res));
          check_field("queue_level", 8'(want.level), 8'(out_queue_level));
          check_field("request_dropped", 8'(want.dropped), 8'(out_request_dropped));
        end
      end
    end
    status_outstanding = status_due.size();
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Beep pattern sequencer testbench
// Drives tick and request beats into the sequencer under several tone and
// millisecond settings and under three idle profiles on both channels. A
// short directed run covers the corner cases, then random traffic follows.
// The status checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;
  import bps_tb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_AW-1:0]    cfg_addr;
  logic [CFG_DW-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_cmd;
  logic [VOL_W-1:0]     in_volume;
  logic [CNT_W-1:0]     in_repeat_count;
  logic [MS_W-1:0]      in_on_ms;
  logic [MS_W-1:0]      in_off_ms;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_tone_out;
  logic                 out_busy_res;
  logic [LEVEL_W-1:0]   out_queue_level;
  logic                 out_request_dropped;

  int                   fail_count;
  int                   status_outstanding;
  int                   tx_idle_pct;
  int                   rx_idle_pct;

  // Idle profiles: sender and receiver percentages.
  int                   tx_pct_tbl [3] = '{37, 66, 0};
  int                   rx_pct_tbl [3] = '{66, 37, 0};

  // Random phases: tone period, clocks per ms and beats in each.
  logic [TP_W-1:0]      tp_tbl  [6] = '{16'd20, 16'd0, 16'd1, 16'd65535, 16'd7, 16'd100};
  logic [CPM_W-1:0]     cpm_tbl [6] = '{20'd2, 20'd0, 20'd1, 20'd3, 20'd1048575, 20'd1};
  int                   len_tbl [6] = '{100, 90, 90, 100, 40, 110};

  beep_pattern_sequencer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_volume           (in_volume),
    .in_repeat_count     (in_repeat_count),
    .in_on_ms            (in_on_ms),
    .in_off_ms           (in_off_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tone_out        (out_tone_out),
    .out_busy_res        (out_busy_res),
    .out_queue_level     (out_queue_level),
    .out_request_dropped (out_request_dropped)
  );

  beep_result_checker status_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_addr            (cfg_addr),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_volume           (in_volume),
    .in_repeat_count     (in_repeat_count),
    .in_on_ms            (in_on_ms),
    .in_off_ms           (in_off_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tone_out        (out_tone_out),
    .out_busy_res        (out_busy_res),
    .out_queue_level     (out_queue_level),
    .out_request_dropped (out_request_dropped),
    .fail_count          (fail_count),
    .status_outstanding  (status_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_idle_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Send one beat: optional idle cycles first, then hold until accepted.
  // Called and returns at a falling edge.
  task automatic send_beat(input logic cmd, input logic [VOL_W-1:0] vol,
                           input logic [CNT_W-1:0] reps, input logic [MS_W-1:0] on_ms,
                           input logic [MS_W-1:0] off_ms);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_volume       <= vol;
    in_repeat_count <= reps;
    in_on_ms        <= on_ms;
    in_off_ms       <= off_ms;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // A tick carries random junk in the request fields.
  task automatic send_tick();
    send_beat(CMD_TICK, VOL_W'($urandom), CNT_W'($urandom), MS_W'($urandom),
              MS_W'($urandom));
  endtask

  // Mostly short valid patterns; some mutes, some zero counts or on times.
  task automatic send_random_request();
    int               pick;
    logic [VOL_W-1:0] vol;
    logic [CNT_W-1:0] reps;
    logic [MS_W-1:0]  on_ms;
    logic [MS_W-1:0]  off_ms;
    pick = $urandom_range(0, 99);
    vol  = ($urandom_range(0, 7) == 0) ? VOL_MUTE : VOL_W'($urandom_range(VOL_LOW, VOL_HIGH));
    if (pick < 6) begin
      reps   = '0;
      on_ms  = MS_W'($urandom);
      off_ms = MS_W'($urandom);
    end else if (pick < 11) begin
      reps   = CNT_W'($urandom);
      on_ms  = '0;
      off_ms = MS_W'($urandom);
    end else begin
      reps   = (pick < 16) ? CNT_W'($urandom) : CNT_W'($urandom_range(1, 3));
      on_ms  = MS_W'($urandom_range(1, 3));
      off_ms = MS_W'($urandom_range(0, 2));
    end
    send_beat(CMD_REQUEST, vol, reps, on_ms, off_ms);
  endtask

  // Stop sending and wait until every predicted status beat has come out.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (status_outstanding != 0);
    repeat (3) @(negedge clk);
  endtask

  // Write both registers; junk in the unused upper bits of the tone write.
  task automatic set_regs(input logic [TP_W-1:0] tp, input logic [CPM_W-1:0] cpm);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_TONE_PERIOD;
    cfg_wdata <= {(CFG_DW - TP_W)'($urandom), tp};
    @(negedge clk);
    cfg_addr  <= CFG_CLOCKS_PER_MS;
    cfg_wdata <= cpm;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int sent;
    int pick;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_addr        = CFG_TONE_PERIOD;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_cmd          = CMD_TICK;
    in_volume       = VOL_MUTE;
    in_repeat_count = '0;
    in_on_ms        = '0;
    in_off_ms       = '0;
    tx_idle_pct     = tx_pct_tbl[0];
    rx_idle_pct     = rx_pct_tbl[0];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: a single beep with zero off time.
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd1, 16'd1, 16'd0);
    send_tick();
    send_tick();
    wait_quiet();
    set_regs(16'd10, 20'd1);

    // Low volume pattern, then a queued request and a queued mute.
    send_beat(CMD_REQUEST, VOL_LOW, 16'd2, 16'd1, 16'd1);
    send_tick();
    send_tick();
    send_beat(CMD_REQUEST, VOL_MED, 16'd1, 16'd2, 16'd0);
    send_beat(CMD_REQUEST, VOL_MUTE, 16'd1, 16'd1, 16'd0);
    send_tick();
    send_tick();
    send_tick();

    // Invalid requests: zero count with wide times, zero on time, invalid mute.
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd0, 16'hFFFF, 16'hFFFF);
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd1, 16'd0, 16'd1);
    send_beat(CMD_REQUEST, VOL_MUTE, 16'd0, 16'd0, 16'd0);

    // Burst that overruns the queue, including a maximum repeat count.
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd2, 16'd1, 16'd0);
    send_beat(CMD_REQUEST, VOL_LOW, 16'd3, 16'd1, 16'd2);
    send_beat(CMD_REQUEST, VOL_MED, 16'hFFFF, 16'd1, 16'd0);
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd2, 16'd2, 16'd1);
    send_beat(CMD_REQUEST, VOL_MED, 16'd1, 16'd1, 16'd1);
    send_beat(CMD_REQUEST, VOL_HIGH, 16'd1, 16'd1, 16'd1);
    repeat (4) send_tick();

    // Random traffic, one register setting and idle profile per phase.
    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      set_regs(tp_tbl[ph], cpm_tbl[ph]);
      tx_idle_pct = tx_pct_tbl[ph / 2];
      rx_idle_pct = rx_pct_tbl[ph / 2];
      sent = 0;
      while (sent < len_tbl[ph]) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          repeat (5) send_random_request();
          sent += 5;
        end else if (pick < 30) begin
          send_random_request();
          sent++;
        end else begin
          send_tick();
          sent++;
        end
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bps_pkg.sv
hw/rtl/bps_cfg_regs.sv
hw/rtl/bps_req_queue.sv
hw/rtl/bps_engine.sv
hw/rtl/beep_pattern_sequencer.sv
tb/beep_result_checker.sv
tb/tb.sv
